// File: src/fcta_pkg.sv
// Shared types and constants for the floor/ceiling texture address generator.
// Used by fcta_div, fcta_ctrl and floor_ceiling_texture_address_gen.
package fcta_pkg;

  localparam int SCREEN_WIDTH_DEF    = 640;
  localparam int SCREEN_HEIGHT_DEF   = 480;
  localparam int FLOOR_TEX_SIZE_DEF  = 64;
  localparam int CEIL_TEX_SIZE_DEF   = 64;
  localparam int BYTES_PER_PIXEL_DEF = 4;

  // divider: 32-bit dividend, 13-bit divisor up to 8191
  localparam int DVD_W  = 32;
  localparam int DVS_W  = 13;
  localparam int CNT_W  = 5;
  // row distance, multiplier operand and product widths
  localparam int RD_W    = 28;
  localparam int MULB_W  = 19;
  localparam int PROD_W  = 48;
  localparam int WORLD_W = 34;

  localparam logic [2:0] CFG_PLAYER_X   = 3'd0;
  localparam logic [2:0] CFG_PLAYER_Y   = 3'd1;
  localparam logic [2:0] CFG_VIEW_DIR_X = 3'd2;
  localparam logic [2:0] CFG_VIEW_DIR_Y = 3'd3;
  localparam logic [2:0] CFG_CAM_PL_X   = 3'd4;
  localparam logic [2:0] CFG_CAM_PL_Y   = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_DS,
    ST_RD_WAIT,
    ST_SX_MUL,
    ST_SX_DS,
    ST_SX_WAIT,
    ST_SY_MUL,
    ST_SY_DS,
    ST_SY_WAIT,
    ST_WX_MUL,
    ST_WX_ADD,
    ST_WY_MUL,
    ST_WY_ADD,
    ST_EMIT
  } fsm_state_e;

  typedef enum logic [1:0] {
    MS_SX,
    MS_SY,
    MS_WX,
    MS_WY
  } mul_sel_e;

  typedef struct packed {
    logic     in_stall;
    logic     div_start;
    logic     div_rd;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     ld_rd;
    logic     ld_sx;
    logic     ld_sy;
    logic     ld_wx;
    logic     ld_wy;
    logic     emit;
  } ctrl_t;

endpackage

// File: src/floor_ceiling_texture_address_gen.sv
// Floor and ceiling texture address generator for a raycaster, top level.
// Depends on fcta_pkg, fcta_div and fcta_ctrl.
//
// Input channel (in_valid_i / in_stall_o) carries one screen pixel per
// transaction. Column 0 of a lower-half row starts a new row: the row
// distance and the two world steps come from one shared 32-bit serial
// divider (three divides in turn) and the start point from one shared
// 29x19 multiplier, and then the output register is loaded. Any other pixel
// is accepted and then loads the output register once that is free.
// In_stall_o is high while a transaction is being worked on.
// Output channel (out_valid_o / out_stall_i) is a single output register; the
// next input transaction is accepted while a result waits, and its own
// result is held back until the register is taken. A stalled result holds.
// Rows outside the lower half give row_valid_o low and zero offsets and
// leave the world point alone.
// Reset clears world point and steps and loads the default view and camera.
// Configuration writes (cfg_we_i) take effect at once; the user must make them
// only while idle, as the block itself does not enforce it.
module floor_ceiling_texture_address_gen #(
  parameter int SCREEN_WIDTH    = fcta_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT   = fcta_pkg::SCREEN_HEIGHT_DEF,
  parameter int FLOOR_TEX_SIZE  = fcta_pkg::FLOOR_TEX_SIZE_DEF,
  parameter int CEIL_TEX_SIZE   = fcta_pkg::CEIL_TEX_SIZE_DEF,
  parameter int BYTES_PER_PIXEL = fcta_pkg::BYTES_PER_PIXEL_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [9:0]  pix_col_i,
  input  logic [8:0]  pix_row_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [13:0] floor_texel_offset_o,
  output logic [13:0] ceil_texel_offset_o,
  output logic [20:0] floor_pixel_offset_o,
  output logic [20:0] ceil_pixel_offset_o,
  output logic        row_valid_o
);
  import fcta_pkg::*;

  localparam int HALF   = SCREEN_HEIGHT / 2;
  localparam int RD_NUM = SCREEN_HEIGHT * 32768;

  function automatic logic [13:0] texel_off(input logic [15:0] fa, input logic [15:0] fb,
                                            input int unsigned size);
    logic [26:0] pa;
    logic [26:0] pb;
    logic [10:0] tx;
    logic [10:0] ty;
    logic [31:0] sum;
    pa  = 27'(size) * {11'b0, fa};
    pb  = 27'(size) * {11'b0, fb};
    tx  = pa[26:16] & 11'(size - 1);
    ty  = pb[26:16] & 11'(size - 1);
    sum = (32'(tx) + 32'(ty) * 32'(size)) * 32'(BYTES_PER_PIXEL);
    return sum[13:0];
  endfunction

  // configuration
  logic        [23:0] player_x_q, player_y_q;
  logic signed [17:0] dir_x_q, dir_y_q, pl_x_q, pl_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      player_x_q <= '0;
      player_y_q <= '0;
      dir_x_q    <= 18'sd65536;
      dir_y_q    <= '0;
      pl_x_q     <= '0;
      pl_y_q     <= 18'sd43254;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PLAYER_X:   player_x_q <= cfg_data_i;
        CFG_PLAYER_Y:   player_y_q <= cfg_data_i;
        CFG_VIEW_DIR_X: dir_x_q    <= cfg_data_i[17:0];
        CFG_VIEW_DIR_Y: dir_y_q    <= cfg_data_i[17:0];
        CFG_CAM_PL_X:   pl_x_q     <= cfg_data_i[17:0];
        CFG_CAM_PL_Y:   pl_y_q     <= cfg_data_i[17:0];
        default: ;
      endcase
    end
  end

  // sequencer
  ctrl_t ctrl;
  logic  accept;
  logic  row_ok_d, row_start;
  logic  div_done;
  logic  out_valid_q;
  logic  out_free;

  assign row_ok_d  = ({4'b0, pix_row_i} > 13'(HALF)) &&
                     ({4'b0, pix_row_i} < 13'(SCREEN_HEIGHT));
  assign row_start = row_ok_d && (pix_col_i == '0);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign accept    = in_valid_i && !ctrl.in_stall;

  fcta_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .row_start_i (row_start),
    .div_done_i  (div_done),
    .out_free_i  (out_free),
    .ctrl_o      (ctrl)
  );

  assign in_stall_o = ctrl.in_stall;

  // captured transaction
  logic [9:0] col_q;
  logic [8:0] row_q;
  logic       row_ok_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      col_q    <= pix_col_i;
      row_q    <= pix_row_i;
      row_ok_q <= row_ok_d;
    end
  end

  // shared multiplier
  logic        [RD_W-1:0]   rd_q;
  logic signed [MULB_W-1:0] mul_b;
  logic signed [PROD_W-1:0] mul_p, prod_q;

  always_comb begin
    case (ctrl.mul_sel)
      MS_SX:   mul_b = {pl_x_q, 1'b0};
      MS_SY:   mul_b = {pl_y_q, 1'b0};
      MS_WX:   mul_b = {dir_x_q[17], dir_x_q} - {pl_x_q[17], pl_x_q};
      MS_WY:   mul_b = {dir_y_q[17], dir_y_q} - {pl_y_q[17], pl_y_q};
      default: mul_b = '0;
    endcase
  end

  assign mul_p = $signed({1'b0, rd_q}) * mul_b;

  always_ff @(posedge clk_i) begin
    if (ctrl.mul_en) begin
      prod_q <= mul_p;
    end
  end

  // shared divider
  logic [31:0]      n16;
  logic             neg;
  logic [DVD_W-1:0] mag;
  logic [DVD_W-1:0] dvd;
  logic [DVS_W-1:0] dvs;
  logic [DVD_W-1:0] div_quo;
  logic [DVS_W-1:0] div_rem;

  assign n16 = prod_q[PROD_W-1:16];
  assign neg = n16[31];
  assign mag = neg ? (~n16 + 32'd1) : n16;
  assign dvd = ctrl.div_rd ? DVD_W'(RD_NUM) : mag;
  assign dvs = ctrl.div_rd ? DVS_W'({4'b0, row_q} - 13'(HALF)) : DVS_W'(SCREEN_WIDTH);

  fcta_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctrl.div_start),
    .dividend_i (dvd),
    .divisor_i  (dvs),
    .done_o     (div_done),
    .quo_o      (div_quo),
    .rem_o      (div_rem)
  );

  // floor of a signed quotient from the magnitude result
  logic [WORLD_W-1:0] q_mag, step_val, start_x, start_y;

  assign q_mag    = {2'b0, div_quo} + WORLD_W'(neg && (div_rem != '0));
  assign step_val = neg ? (~q_mag + 1'b1) : q_mag;
  assign start_x  = {10'b0, player_x_q} + {{2{n16[31]}}, n16};
  assign start_y  = {10'b0, player_y_q} + {{2{n16[31]}}, n16};

  logic [WORLD_W-1:0] world_x_q, world_y_q, step_x_q, step_y_q;

  always_ff @(posedge clk_i) begin
    if (ctrl.ld_rd) begin
      rd_q <= div_quo[RD_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      world_x_q <= '0;
      world_y_q <= '0;
      step_x_q  <= '0;
      step_y_q  <= '0;
    end else begin
      if (ctrl.ld_sx) step_x_q <= step_val;
      if (ctrl.ld_sy) step_y_q <= step_val;
      if (ctrl.ld_wx) begin
        world_x_q <= start_x;
      end else if (ctrl.emit && row_ok_q) begin
        world_x_q <= world_x_q + step_x_q;
      end
      if (ctrl.ld_wy) begin
        world_y_q <= start_y;
      end else if (ctrl.emit && row_ok_q) begin
        world_y_q <= world_y_q + step_y_q;
      end
    end
  end

  // result formatting
  logic [13:0] ftex, ctex;
  logic [31:0] fpix, cpix;

  always_comb begin
    ftex = texel_off(world_x_q[15:0], world_y_q[15:0], FLOOR_TEX_SIZE);
    ctex = texel_off(world_x_q[15:0], world_y_q[15:0], CEIL_TEX_SIZE);
    fpix = (32'(row_q) * 32'(SCREEN_WIDTH) + 32'(col_q)) * 32'(BYTES_PER_PIXEL);
    cpix = ((32'(SCREEN_HEIGHT) - 32'(row_q) - 32'd1) * 32'(SCREEN_WIDTH) + 32'(col_q))
           * 32'(BYTES_PER_PIXEL);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.emit) begin
      floor_texel_offset_o <= row_ok_q ? ftex : '0;
      ceil_texel_offset_o  <= row_ok_q ? ctex : '0;
      floor_pixel_offset_o <= row_ok_q ? fpix[20:0] : '0;
      ceil_pixel_offset_o  <= row_ok_q ? cpix[20:0] : '0;
      row_valid_o          <= row_ok_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: src/fcta_div.sv
// Shift-subtract unsigned divider, one quotient bit per cycle.
// Depends on fcta_pkg for operand widths.
module fcta_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [fcta_pkg::DVD_W-1:0] dividend_i,
  input  logic [fcta_pkg::DVS_W-1:0] divisor_i,
  output logic                       done_o,
  output logic [fcta_pkg::DVD_W-1:0] quo_o,
  output logic [fcta_pkg::DVS_W-1:0] rem_o
);
  import fcta_pkg::*;

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DVD_W-1:0] quo_q;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q;
  logic [DVS_W:0]   trial;
  logic             ge;

  always_comb begin
    trial = {rem_q, quo_q[DVD_W-1]};
    ge    = (trial >= {1'b0, dvs_q});
    if (ge) begin
      rem_d = DVS_W'(trial - {1'b0, dvs_q});
    end else begin
      rem_d = trial[DVS_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DVD_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[DVD_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

// File: src/fcta_ctrl.sv
// Sequencer for the row set-up (divides, multiplies, adds) and result hand-off.
// Depends on fcta_pkg for the state enum and control struct.
module fcta_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            row_start_i,
  input  logic            div_done_i,
  input  logic            out_free_i,
  output fcta_pkg::ctrl_t ctrl_o
);
  import fcta_pkg::*;

  fsm_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = row_start_i ? ST_RD_DS : ST_EMIT;
        end
      end
      ST_RD_DS:   state_d = ST_RD_WAIT;
      ST_RD_WAIT: if (div_done_i) state_d = ST_SX_MUL;
      ST_SX_MUL:  state_d = ST_SX_DS;
      ST_SX_DS:   state_d = ST_SX_WAIT;
      ST_SX_WAIT: if (div_done_i) state_d = ST_SY_MUL;
      ST_SY_MUL:  state_d = ST_SY_DS;
      ST_SY_DS:   state_d = ST_SY_WAIT;
      ST_SY_WAIT: if (div_done_i) state_d = ST_WX_MUL;
      ST_WX_MUL:  state_d = ST_WX_ADD;
      ST_WX_ADD:  state_d = ST_WY_MUL;
      ST_WY_MUL:  state_d = ST_WY_ADD;
      ST_WY_ADD:  state_d = ST_EMIT;
      ST_EMIT:    if (out_free_i) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o           = '0;
    ctrl_o.mul_sel   = MS_SX;
    ctrl_o.in_stall  = (state_q != ST_IDLE);
    case (state_q)
      ST_RD_DS: begin
        ctrl_o.div_start = 1'b1;
        ctrl_o.div_rd    = 1'b1;
      end
      ST_RD_WAIT: ctrl_o.ld_rd = div_done_i;
      ST_SX_MUL: begin
        ctrl_o.mul_en  = 1'b1;
        ctrl_o.mul_sel = MS_SX;
      end
      ST_SX_DS:   ctrl_o.div_start = 1'b1;
      ST_SX_WAIT: ctrl_o.ld_sx = div_done_i;
      ST_SY_MUL: begin
        ctrl_o.mul_en  = 1'b1;
        ctrl_o.mul_sel = MS_SY;
      end
      ST_SY_DS:   ctrl_o.div_start = 1'b1;
      ST_SY_WAIT: ctrl_o.ld_sy = div_done_i;
      ST_WX_MUL: begin
        ctrl_o.mul_en  = 1'b1;
        ctrl_o.mul_sel = MS_WX;
      end
      ST_WX_ADD:  ctrl_o.ld_wx = 1'b1;
      ST_WY_MUL: begin
        ctrl_o.mul_en  = 1'b1;
        ctrl_o.mul_sel = MS_WY;
      end
      ST_WY_ADD:  ctrl_o.ld_wy = 1'b1;
      ST_EMIT:    ctrl_o.emit = out_free_i;
      default: ;
    endcase
  end

endmodule

// File: tb/tb_floor_ceiling_texture_address_gen.sv
// Self-checking bench for floor_ceiling_texture_address_gen: a directed table, then random
// row sweeps under several views, untyped items checked by a built-in Q18.16 predictor.
// Depends on fcta_pkg and the RTL of floor_ceiling_texture_address_gen.
module tb_floor_ceiling_texture_address_gen;
  import fcta_pkg::*;

  localparam int SW  = SCREEN_WIDTH_DEF;
  localparam int SH  = SCREEN_HEIGHT_DEF;
  localparam int FTS = FLOOR_TEX_SIZE_DEF;
  localparam int CTS = CEIL_TEX_SIZE_DEF;
  localparam int BPP = BYTES_PER_PIXEL_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DIR_N = 20;

  typedef struct packed {
    logic [13:0] ftex;
    logic [13:0] ctex;
    logic [20:0] fpix;
    logic [20:0] cpix;
    logic        row_ok;
  } pix_result_t;

  typedef struct {
    int col;
    int row;
    bit typed;
    int ftex;
    int ctex;
    int fpix;
    int cpix;
    bit rv;
  } pixel_case_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = CFG_PLAYER_X;
  logic [23:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [9:0]  pix_col_i = '0;
  logic [8:0]  pix_row_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [13:0] floor_texel_offset_o;
  logic [13:0] ceil_texel_offset_o;
  logic [20:0] floor_pixel_offset_o;
  logic [20:0] ceil_pixel_offset_o;
  logic        row_valid_o;

  // predictor copy of the view registers and the world walk
  logic [23:0]        cfg_player_x = '0;
  logic [23:0]        cfg_player_y = '0;
  logic signed [17:0] cfg_dir_x = 18'sd65536;
  logic signed [17:0] cfg_dir_y = '0;
  logic signed [17:0] cfg_plane_x = '0;
  logic signed [17:0] cfg_plane_y = 18'sd43254;
  logic [33:0]        pos_x = '0;
  logic [33:0]        pos_y = '0;
  logic [33:0]        inc_x = '0;
  logic [33:0]        inc_y = '0;

  pix_result_t pending_results[$];
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int mismatch_count = 0;
  int n_items = 0;
  int n_checked = 0;
  int n_row_starts = 0;
  int cycle_count = 0;

  // pixels before any row start, rows outside the lower half, row starts, columns past the width
  pixel_case_t directed_plan [DIR_N] = '{
    '{5,    241, 1'b1, 0, 0, 616980, 609300, 1'b1},
    '{0,    0,   1'b1, 0, 0, 0, 0, 1'b0},
    '{1023, 240, 1'b1, 0, 0, 0, 0, 1'b0},
    '{0,    480, 1'b1, 0, 0, 0, 0, 1'b0},
    '{1023, 511, 1'b1, 0, 0, 0, 0, 1'b0},
    '{0,    241, 1'b0, 0, 0, 0, 0, 1'b0},
    '{1,    241, 1'b0, 0, 0, 0, 0, 1'b0},
    '{2,    241, 1'b0, 0, 0, 0, 0, 1'b0},
    '{0,    479, 1'b0, 0, 0, 0, 0, 1'b0},
    '{639,  479, 1'b0, 0, 0, 0, 0, 1'b0},
    '{640,  479, 1'b0, 0, 0, 0, 0, 1'b0},
    '{1023, 479, 1'b0, 0, 0, 0, 0, 1'b0},
    '{0,    300, 1'b0, 0, 0, 0, 0, 1'b0},
    '{1,    300, 1'b0, 0, 0, 0, 0, 1'b0},
    '{2,    300, 1'b0, 0, 0, 0, 0, 1'b0},
    '{3,    300, 1'b0, 0, 0, 0, 0, 1'b0},
    '{0,    256, 1'b0, 0, 0, 0, 0, 1'b0},
    '{512,  256, 1'b0, 0, 0, 0, 0, 1'b0},
    '{5,    100, 1'b1, 0, 0, 0, 0, 1'b0},
    '{6,    256, 1'b0, 0, 0, 0, 0, 1'b0}
  };

  floor_ceiling_texture_address_gen DUT (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_idx_i            (cfg_idx_i),
    .cfg_data_i           (cfg_data_i),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .pix_col_i            (pix_col_i),
    .pix_row_i            (pix_row_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .floor_texel_offset_o (floor_texel_offset_o),
    .ceil_texel_offset_o  (ceil_texel_offset_o),
    .floor_pixel_offset_o (floor_pixel_offset_o),
    .ceil_pixel_offset_o  (ceil_pixel_offset_o),
    .row_valid_o          (row_valid_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic longint floor_quot(longint n, longint d);
    longint q;
    q = n / d;
    if ((n % d) != 0 && n < 0) q--;
    return q;
  endfunction

  function automatic logic [13:0] texel_offset(logic [33:0] wa, logic [33:0] wb, longint size);
    longint fa, fb, tx, ty, o;
    fa = wa[15:0];
    fb = wb[15:0];
    tx = ((size * fa) >> 16) & (size - 1);
    ty = ((size * fb) >> 16) & (size - 1);
    o = (tx + ty * size) * BPP;
    return o[13:0];
  endfunction

  function automatic pix_result_t predict_pixel(logic [9:0] col, logic [8:0] row);
    pix_result_t r;
    longint c, rw, p, rd, tmp;
    r = '0;
    c = col;
    rw = row;
    if (rw <= SH / 2 || rw >= SH) return r;
    if (c == 0) begin
      n_row_starts++;
      p = rw - SH / 2;
      rd = (longint'(SH) << 15) / p;
      tmp = floor_quot(rd * (2 * longint'(cfg_plane_x)), longint'(SW) * 65536);
      inc_x = tmp[33:0];
      tmp = floor_quot(rd * (2 * longint'(cfg_plane_y)), longint'(SW) * 65536);
      inc_y = tmp[33:0];
      tmp = longint'(cfg_player_x)
            + floor_quot(rd * (longint'(cfg_dir_x) - longint'(cfg_plane_x)), 65536);
      pos_x = tmp[33:0];
      tmp = longint'(cfg_player_y)
            + floor_quot(rd * (longint'(cfg_dir_y) - longint'(cfg_plane_y)), 65536);
      pos_y = tmp[33:0];
    end
    r.ftex = texel_offset(pos_x, pos_y, FTS);
    r.ctex = texel_offset(pos_x, pos_y, CTS);
    tmp = (rw * SW + c) * BPP;
    r.fpix = tmp[20:0];
    tmp = ((SH - rw - 1) * SW + c) * BPP;
    r.cpix = tmp[20:0];
    r.row_ok = 1'b1;
    pos_x = pos_x + inc_x;
    pos_y = pos_y + inc_y;
    return r;
  endfunction

  task automatic note_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [20:0] got, logic [20:0] want);
    if (got !== want)
      note_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  task automatic write_reg(logic [2:0] idx, logic [23:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      CFG_PLAYER_X:   cfg_player_x = data;
      CFG_PLAYER_Y:   cfg_player_y = data;
      CFG_VIEW_DIR_X: cfg_dir_x = data[17:0];
      CFG_VIEW_DIR_Y: cfg_dir_y = data[17:0];
      CFG_CAM_PL_X:   cfg_plane_x = data[17:0];
      CFG_CAM_PL_Y:   cfg_plane_y = data[17:0];
      default: ;
    endcase
  endtask

  task automatic set_view(int px, int py, int dx, int dy, int cx, int cy);
    write_reg(CFG_PLAYER_X, px[23:0]);
    write_reg(CFG_PLAYER_Y, py[23:0]);
    write_reg(CFG_VIEW_DIR_X, {6'b0, dx[17:0]});
    write_reg(CFG_VIEW_DIR_Y, {6'b0, dy[17:0]});
    write_reg(CFG_CAM_PL_X, {6'b0, cx[17:0]});
    write_reg(CFG_CAM_PL_Y, {6'b0, cy[17:0]});
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // valid stays high after a transaction; callers that pause lower it themselves
  task automatic send_pixel(int col, int row, bit typed, pix_result_t typed_res);
    pix_result_t predicted;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pix_col_i <= col[9:0];
    pix_row_i <= row[8:0];
    do @(posedge clk_i); while (in_stall_o);
    predicted = predict_pixel(col[9:0], row[8:0]);
    pending_results.push_back(typed ? typed_res : predicted);
    n_items++;
  endtask

  task automatic wait_results_done();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // mostly row start then a run of columns; some noise and rows entered mid-way
  task automatic run_random_rows(int n);
    int done_pix, run_len, first_col, row, pick;
    bit drained;
    done_pix = 0;
    drained = 1'b0;
    while (done_pix < n) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        case ($urandom_range(9))
          0: row = SH / 2 + 1;
          1: row = SH - 1;
          default: row = $urandom_range(SH / 2 + 1, SH - 1);
        endcase
        send_pixel(0, row, 1'b0, '0);
        done_pix++;
        run_len = ($urandom_range(19) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
        first_col = ($urandom_range(9) == 0) ? $urandom_range(1, 1023) : 1;
        for (int i = 0; i < run_len; i++) begin
          send_pixel((first_col + i) % 1024, row, 1'b0, '0);
          done_pix++;
        end
      end else if (pick < 90) begin
        row = $urandom_range(0, 511);
        send_pixel($urandom_range(0, 1023), row, 1'b0, '0);
        if (row > SH / 2 && row < SH) done_pix++;
      end else begin
        send_pixel($urandom_range(1, 1023), $urandom_range(SH / 2 + 1, SH - 1), 1'b0, '0);
        done_pix++;
      end
      if (!drained && done_pix >= n / 2) begin
        wait_results_done();
        drained = 1'b1;
      end
    end
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < rx_idle_pct);
  end

  always @(posedge clk_i) begin : check_result
    pix_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        note_mismatch("result with no transaction pending");
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        check_field("floor_texel_offset", floor_texel_offset_o, want.ftex);
        check_field("ceil_texel_offset", ceil_texel_offset_o, want.ctex);
        check_field("floor_pixel_offset", floor_pixel_offset_o, want.fpix);
        check_field("ceil_pixel_offset", ceil_pixel_offset_o, want.cpix);
        check_field("row_valid", row_valid_o, want.row_ok);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    pix_result_t typed_res;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    tx_idle_pct = 15;
    rx_idle_pct = 72;
    foreach (directed_plan[i]) begin
      typed_res.ftex = directed_plan[i].ftex[13:0];
      typed_res.ctex = directed_plan[i].ctex[13:0];
      typed_res.fpix = directed_plan[i].fpix[20:0];
      typed_res.cpix = directed_plan[i].cpix[20:0];
      typed_res.row_ok = directed_plan[i].rv;
      send_pixel(directed_plan[i].col, directed_plan[i].row, directed_plan[i].typed,
                 typed_res);
    end
    wait_results_done();

    for (int ph = 1; ph <= 6; ph++) begin
      case (ph)
        1: set_view(24'hFFFFFF, 24'hFFFFFF, 131071, -131072, -131072, 131071);
        2: set_view(0, 0, -131072, 131071, 131071, -131072);
        default: set_view($urandom_range(0, 24'hFFFFFF), $urandom_range(0, 24'hFFFFFF),
                          $urandom_range(0, 18'h3FFFF), $urandom_range(0, 18'h3FFFF),
                          $urandom_range(0, 18'h3FFFF), $urandom_range(0, 18'h3FFFF));
      endcase
      if (ph <= 2) begin
        tx_idle_pct = 15;
        rx_idle_pct = 72;
      end else if (ph <= 4) begin
        tx_idle_pct = 72;
        rx_idle_pct = 15;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      run_random_rows(120);
      wait_results_done();
    end

    repeat (150) @(posedge clk_i);
    $display("covered %0d pixel transactions, %0d row starts, %0d results checked",
             n_items, n_row_starts, n_checked);
    $display("view settings: reset, both extremes, four random; idling both ways and none");
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: sim.f
src/fcta_pkg.sv
src/fcta_div.sv
src/fcta_ctrl.sv
src/floor_ceiling_texture_address_gen.sv
tb/tb_floor_ceiling_texture_address_gen.sv
